### src/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the depth shell triangulator
// Geometry limits, field widths, register indexes and the structs that pass
// between the front, the command queue and the back.
// ----------------------------------------------------------------------------
package dst_pkg;

  // image size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 512;

  // derived widths
  localparam int X_W = $clog2(MAX_WIDTH);
  localparam int Y_W = $clog2(MAX_HEIGHT);
  localparam int W_W = X_W + 1;
  localparam int H_W = Y_W + 1;

  // fixed field widths
  localparam int D_W        = 16;
  localparam int V_W        = 18;
  localparam int CUTOFF_W   = 16;
  localparam int STEP_W     = 16;
  localparam int WIDTH_W    = 9;
  localparam int HEIGHT_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALID_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_USED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_USED  = 2'd3;

  // register reset values
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 16'd50;
  localparam logic [STEP_W-1:0]   STEP_RST   = 16'd50;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 9'd212;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd512;

  // command queue size
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // clamped geometry and thresholds
  typedef struct packed {
    logic [CUTOFF_W-1:0] cutoff;
    logic [STEP_W-1:0]   step;
    logic [W_W-1:0]      w;
    logic [H_W-1:0]      h;
    logic [V_W-1:0]      wh;
  } geom_t;

  // one classified cell that produces at least one triangle
  typedef struct packed {
    logic           near;
    logic           br_b;
    logic           f1;
    logic           f2;
    logic [V_W-1:0] idx;
  } cmd_t;

  // one result triangle
  typedef struct packed {
    logic [V_W-1:0] a;
    logic [V_W-1:0] b;
    logic [V_W-1:0] c;
    logic           wall;
    logic           last;
  } tri_t;

endpackage

### src/dst_front.sv
// ----------------------------------------------------------------------------
// dst_front: pixel intake and cell classification
// Tracks the raster position, keeps the previous row in a memory, tests the
// 2x2 cell and hands cells that produce triangles to the command queue.
// ----------------------------------------------------------------------------
module dst_front import dst_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  geom_t          geom_i,
  input  logic           push,
  output logic           full,
  input  logic [D_W-1:0] depth_sample_i,
  input  logic           frame_start_i,
  input  logic           cmd_full_i,
  output logic           cmd_push_o,
  output cmd_t           cmd_o
);

  logic [X_W-1:0] col_q;
  logic [Y_W-1:0] row_q;
  logic           layer_q;
  logic [D_W-1:0] left_q;
  logic [D_W-1:0] up_q;
  logic [D_W-1:0] row_mem [MAX_WIDTH];

  logic           s1_vld_q;
  logic [D_W-1:0] s1_cur_q, s1_lf_q, s1_ul_q;
  logic [X_W-1:0] s1_x_q;
  logic [Y_W-1:0] s1_y_q;
  logic           s1_layer_q;

  logic           accept, s1_go, emit;
  logic [X_W-1:0] x;
  logic [Y_W-1:0] y;
  logic           lay;
  logic [W_W-1:0] x_inc;
  logic [H_W-1:0] y_inc;

  // position of the incoming pixel
  always_comb begin
    x     = frame_start_i ? '0 : col_q;
    y     = frame_start_i ? '0 : row_q;
    lay   = frame_start_i ? 1'b0 : layer_q;
    x_inc = W_W'(x) + W_W'(1);
    y_inc = H_W'(y) + H_W'(1);
  end

  // stage handshake
  assign s1_go  = !s1_vld_q || !emit || !cmd_full_i;
  assign full   = !s1_go;
  assign accept = push && s1_go;

  // raster counters and left neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      layer_q <= 1'b0;
      left_q  <= '0;
    end else if (accept) begin
      left_q <= depth_sample_i;
      if (x_inc >= geom_i.w) begin
        col_q <= '0;
        if (y_inc >= geom_i.h) begin
          row_q   <= '0;
          layer_q <= !lay;
        end else begin
          row_q   <= y_inc[Y_W-1:0];
          layer_q <= lay;
        end
      end else begin
        col_q   <= x_inc[X_W-1:0];
        row_q   <= y;
        layer_q <= lay;
      end
    end
  end

  // previous row memory, read before write at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_mem[x] <= depth_sample_i;
      up_q       <= row_mem[x];
    end
  end

  // classify stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  // classify stage payload; upper-left is the previous pixel's upper depth
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q   <= depth_sample_i;
      s1_lf_q    <= left_q;
      s1_ul_q    <= up_q;
      s1_x_q     <= x;
      s1_y_q     <= y;
      s1_layer_q <= lay;
    end
  end

  // validity and step tests
  function automatic logic close_f(logic [D_W-1:0] a, logic [D_W-1:0] b,
                                   logic [STEP_W-1:0] lim);
    logic [D_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d <= lim;
  endfunction

  logic v_cur, v_lf, v_up, v_ul;
  logic c_lf_cur, c_up_cur, c_lf_ul, c_up_ul;
  logic inner, br_a, br_b, f1, f2;
  logic [V_W-1:0]     row_base, idx;
  logic [Y_W+W_W-1:0] row_prod;

  always_comb begin
    v_cur    = s1_cur_q >= geom_i.cutoff;
    v_lf     = s1_lf_q  >= geom_i.cutoff;
    v_up     = up_q     >= geom_i.cutoff;
    v_ul     = s1_ul_q  >= geom_i.cutoff;
    c_lf_cur = close_f(s1_lf_q, s1_cur_q, geom_i.step);
    c_up_cur = close_f(up_q, s1_cur_q, geom_i.step);
    c_lf_ul  = close_f(s1_lf_q, s1_ul_q, geom_i.step);
    c_up_ul  = close_f(up_q, s1_ul_q, geom_i.step);
    inner    = (s1_x_q != '0) && (s1_y_q != '0);
    br_a     = v_lf && v_up;
    br_b     = !br_a && v_cur && v_ul;
    if (br_a) begin
      f1 = v_cur && c_lf_cur && c_up_cur;
      f2 = v_ul && c_lf_ul && c_up_ul;
    end else begin
      f1 = br_b && v_lf && c_lf_cur && c_lf_ul;
      f2 = br_b && v_up && c_up_cur && c_up_ul;
    end
    f1   = f1 && inner;
    f2   = f2 && inner;
    emit = f1 || f2;
  end

  // vertex index of the current pixel
  always_comb begin
    row_prod = (Y_W+W_W)'(s1_y_q) * (Y_W+W_W)'(geom_i.w);
    row_base = V_W'(row_prod);
    idx      = (s1_layer_q ? geom_i.wh : '0) + row_base + V_W'(s1_x_q);
  end

  // command out
  assign cmd_push_o = s1_vld_q && emit && !cmd_full_i;
  always_comb begin
    cmd_o.near = !s1_layer_q;
    cmd_o.br_b = !br_a;
    cmd_o.f1   = f1;
    cmd_o.f2   = f2;
    cmd_o.idx  = idx;
  end

endmodule

### src/dst_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dst_cmd_fifo: command queue between front and back
// Short first-in first-out store of classified cells.
// ----------------------------------------------------------------------------
module dst_cmd_fifo import dst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_q, rd_q;
  logic [CMD_PTR_W:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + CMD_PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + CMD_PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (CMD_PTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (CMD_PTR_W+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= cmd_i;
  end

endmodule

### src/dst_back.sv
// ----------------------------------------------------------------------------
// dst_back: triangle sequencer
// Expands one cell command into its surface and wall triangles, one per
// cycle into a two-entry result queue while it has room.
// ----------------------------------------------------------------------------
module dst_back import dst_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  geom_t          geom_i,
  input  logic           cmd_empty_i,
  input  cmd_t           cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output tri_t           tri_o
);

  // triangle kinds within a cell
  localparam logic [2:0] K_S1  = 3'd0;
  localparam logic [2:0] K_S2  = 3'd1;
  localparam logic [2:0] K_W1A = 3'd2;
  localparam logic [2:0] K_W1B = 3'd3;
  localparam logic [2:0] K_W2A = 3'd4;
  localparam logic [2:0] K_W2B = 3'd5;

  logic [1:0]     k_q;
  logic [1:0]     n_tri;
  logic [2:0]     kind;
  logic           wr, last;
  tri_t           tri_d;
  logic [V_W-1:0] i0, iL, iU, iUL, q0, qL, qU, qUL;

  tri_t           out_q [2];
  logic           owr_q, ord_q;
  logic [1:0]     ocnt_q;
  logic           ofull, do_pop;

  // triangle count and position within the cell
  always_comb begin
    n_tri = 2'(cmd_i.f1) + 2'(cmd_i.f2);
    if (cmd_i.near && (cmd_i.f1 != cmd_i.f2)) n_tri = n_tri + 2'd2;
    last = k_q == (n_tri - 2'd1);
  end

  // which triangle this step produces
  always_comb begin
    priority if (cmd_i.f1 && k_q == 2'd0) kind = K_S1;
    else if (cmd_i.f1 && cmd_i.f2)        kind = K_S2;
    else if (cmd_i.f1)                    kind = (k_q == 2'd1) ? K_W1A : K_W1B;
    else if (k_q == 2'd0)                 kind = K_S2;
    else                                  kind = (k_q == 2'd1) ? K_W2A : K_W2B;
  end

  // neighbor indices, far copies offset by one image
  always_comb begin
    i0  = cmd_i.idx;
    iL  = cmd_i.idx - V_W'(1);
    iU  = cmd_i.idx - V_W'(geom_i.w);
    iUL = iU - V_W'(1);
    q0  = i0 + geom_i.wh;
    qL  = iL + geom_i.wh;
    qU  = iU + geom_i.wh;
    qUL = iUL + geom_i.wh;
  end

  // vertex selection; near surfaces swap the last two vertices
  always_comb begin
    tri_d.wall = 1'b1;
    tri_d.last = last;
    unique case (kind)
      K_S1: begin
        tri_d.wall = 1'b0;
        if (!cmd_i.br_b) begin
          tri_d.a = iL;
          tri_d.b = cmd_i.near ? iU : i0;
          tri_d.c = cmd_i.near ? i0 : iU;
        end else begin
          tri_d.a = i0;
          tri_d.b = cmd_i.near ? iL : iUL;
          tri_d.c = cmd_i.near ? iUL : iL;
        end
      end
      K_S2: begin
        tri_d.wall = 1'b0;
        if (!cmd_i.br_b) begin
          tri_d.a = iL;
          tri_d.b = cmd_i.near ? iUL : iU;
          tri_d.c = cmd_i.near ? iU : iUL;
        end else begin
          tri_d.a = i0;
          tri_d.b = cmd_i.near ? iUL : iU;
          tri_d.c = cmd_i.near ? iU : iUL;
        end
      end
      K_W1A: begin
        if (!cmd_i.br_b) begin
          tri_d.a = iU; tri_d.b = iL; tri_d.c = qL;
        end else begin
          tri_d.a = i0; tri_d.b = iUL; tri_d.c = q0;
        end
      end
      K_W1B: begin
        if (!cmd_i.br_b) begin
          tri_d.a = qL; tri_d.b = qU; tri_d.c = iU;
        end else begin
          tri_d.a = qUL; tri_d.b = q0; tri_d.c = i0;
        end
      end
      K_W2A: begin
        if (!cmd_i.br_b) begin
          tri_d.a = iU; tri_d.b = qL; tri_d.c = iL;
        end else begin
          tri_d.a = q0; tri_d.b = iUL; tri_d.c = i0;
        end
      end
      default: begin
        if (!cmd_i.br_b) begin
          tri_d.a = qL; tri_d.b = iU; tri_d.c = qU;
        end else begin
          tri_d.a = qUL; tri_d.b = i0; tri_d.c = q0;
        end
      end
    endcase
  end

  // step control
  assign ofull     = ocnt_q == 2'd2;
  assign wr        = !cmd_empty_i && !ofull;
  assign cmd_pop_o = wr && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (wr) begin
      k_q <= last ? 2'd0 : k_q + 2'd1;
    end
  end

  // result queue
  assign empty  = ocnt_q == 2'd0;
  assign do_pop = pop && !empty;
  assign tri_o  = out_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (wr)     owr_q <= !owr_q;
      if (do_pop) ord_q <= !ord_q;
      if (wr && !do_pop)      ocnt_q <= ocnt_q + 2'd1;
      else if (do_pop && !wr) ocnt_q <= ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) out_q[owr_q] <= tri_d;
  end

endmodule

### src/depth_shell_triangulator.sv
// ----------------------------------------------------------------------------
// depth_shell_triangulator: depth map grid triangulation
// Turns a raster stream of near and far depth images into triangle vertex
// index triples, with wall triangles joining single near triangles to the
// far layer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  pixel     in         push / full          depth_sample_i, frame_start_i
//  triangle  out        empty / pop          vertex_a/b/c_o, is_wall_o,
//                                            last_of_pixel_o
//  config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
//  a pixel is taken whenever full is low; the back emits one triangle per
//  cycle while its result queue has room, and a pixel yields 0 to 3
//  triangles; the first triangle reaches the result ports through the
//  front stage register, the command queue and the result queue
//  reset clears counters, queues and registers; the row memory is not cleared
//  full rises when the command queue is full behind a cell to hand over;
//  empty hides the result queue until a triangle is stored
// ----------------------------------------------------------------------------
module depth_shell_triangulator import dst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [D_W-1:0]        depth_sample_i,
  input  logic                  frame_start_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [V_W-1:0]        vertex_a_o,
  output logic [V_W-1:0]        vertex_b_o,
  output logic [V_W-1:0]        vertex_c_o,
  output logic                  is_wall_o,
  output logic                  last_of_pixel_o
);

  logic [CUTOFF_W-1:0] cutoff_q;
  logic [STEP_W-1:0]   step_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [V_W-1:0]      wh_q;
  logic [W_W-1:0]      w_c;
  logic [H_W-1:0]      h_c;
  logic [W_W+H_W-1:0]  wh_prod;
  geom_t               geom;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;
  tri_t tri_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      step_q   <= STEP_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VALID_CUTOFF: cutoff_q <= CUTOFF_W'(cfg_data_i);
        REG_MAX_STEP:     step_q   <= STEP_W'(cfg_data_i);
        REG_WIDTH_USED:   width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT_USED:  height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (width_q < WIDTH_W'(2))             w_c = W_W'(2);
    else if (32'(width_q) > MAX_WIDTH)     w_c = W_W'(MAX_WIDTH);
    else                                   w_c = W_W'(width_q);
    if (height_q < HEIGHT_W'(2))           h_c = H_W'(2);
    else if (32'(height_q) > MAX_HEIGHT)   h_c = H_W'(MAX_HEIGHT);
    else                                   h_c = H_W'(height_q);
    wh_prod = (W_W+H_W)'(w_c) * (W_W+H_W)'(h_c);
  end

  // image size product, registered from the clamped sizes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q <= '0;
    end else begin
      wh_q <= V_W'(wh_prod);
    end
  end

  always_comb begin
    geom.cutoff = cutoff_q;
    geom.step   = step_q;
    geom.w      = w_c;
    geom.h      = h_c;
    geom.wh     = wh_q;
  end

  // pixel intake and classification
  dst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .push           (push),
    .full           (full),
    .depth_sample_i (depth_sample_i),
    .frame_start_i  (frame_start_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  // cell command queue
  dst_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_head)
  );

  // triangle sequencer and result queue
  dst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .tri_o       (tri_out)
  );

  assign vertex_a_o      = tri_out.a;
  assign vertex_b_o      = tri_out.b;
  assign vertex_c_o      = tri_out.c;
  assign is_wall_o       = tri_out.wall;
  assign last_of_pixel_o = tri_out.last;

endmodule
